[sv/rgb_to_hsv_converter_macros.svh]
// assertion helpers for the rgb to hsv converter
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define RHC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RHC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/rhc_pkg.sv]
package rhc_pkg;

    localparam int CH_W       = 8;
    localparam int HUE_W      = 15;
    localparam int SAT_W      = 16;
    localparam int SAT_FRAC   = 15;
    localparam int HUE_Q_W    = 12;
    localparam int HUE_NUM_W  = 20;

    // long division: numerator width, steps per stage, stage count
    localparam int DIV_W      = 24;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = DIV_W / DIV_STEPS;

    localparam logic [HUE_Q_W-1:0] HUE_SCALE  = 12'd3840;
    localparam logic [HUE_W-1:0]   BASE_RED   = 15'd0;
    localparam logic [HUE_W-1:0]   BASE_GREEN = 15'd7680;
    localparam logic [HUE_W-1:0]   BASE_BLUE  = 15'd15360;
    localparam logic [HUE_W:0]     FULL_TURN  = 16'd23040;
    localparam logic [SAT_W-1:0]   SAT_ONE    = 16'd32768;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        t_sector           sector;
        logic              neg;
        logic              grey;
        logic              black;
        logic [CH_W-1:0]   value;
    } t_side;

    // numerator bits shift out of the top, quotient bits shift in at the bottom
    typedef struct packed {
        logic [DIV_W-1:0]  nq;
        logic [CH_W-1:0]   rem;
        logic [CH_W-1:0]   den;
    } t_lane;

    typedef struct packed {
        t_side side;
        t_lane sat;
        t_lane hue;
    } t_div;

    function automatic t_lane div_steps(input t_lane lin);
        t_lane          l;
        logic [CH_W:0]  part;
        l = lin;
        for (int k = 0; k < DIV_STEPS; k++) begin
            part = {l.rem, l.nq[DIV_W-1]};
            if (part >= {1'b0, l.den}) begin
                l.rem = CH_W'(part - {1'b0, l.den});
                l.nq  = {l.nq[DIV_W-2:0], 1'b1};
            end else begin
                l.rem = part[CH_W-1:0];
                l.nq  = {l.nq[DIV_W-2:0], 1'b0};
            end
        end
        return l;
    endfunction

endpackage

[sv/rhc_prep.sv]
module rhc_prep (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [rhc_pkg::CH_W-1:0]     i_red,
    input  logic [rhc_pkg::CH_W-1:0]     i_green,
    input  logic [rhc_pkg::CH_W-1:0]     i_blue,
    output logic                         o_valid,
    output rhc_pkg::t_div                o_div
);

    // stage a: max, min, sector and signed numerator
    logic                         r_a_valid;
    rhc_pkg::t_sector             r_a_sector;
    logic [rhc_pkg::CH_W-1:0]     r_a_max;
    logic [rhc_pkg::CH_W-1:0]     r_a_min;
    logic signed [rhc_pkg::CH_W:0] r_a_num;

    rhc_pkg::t_sector             n_a_sector;
    logic [rhc_pkg::CH_W-1:0]     n_a_max;
    logic [rhc_pkg::CH_W-1:0]     n_a_min;
    logic signed [rhc_pkg::CH_W:0] n_a_num;

    always_comb begin
        // ties go to red, then green
        priority if (i_red >= i_green && i_red >= i_blue) begin
            n_a_sector = rhc_pkg::SEC_RED;
            n_a_max    = i_red;
        end else if (i_green >= i_blue) begin
            n_a_sector = rhc_pkg::SEC_GREEN;
            n_a_max    = i_green;
        end else begin
            n_a_sector = rhc_pkg::SEC_BLUE;
            n_a_max    = i_blue;
        end
        n_a_min = i_red;
        if (i_green < n_a_min) n_a_min = i_green;
        if (i_blue < n_a_min) n_a_min = i_blue;
        unique case (n_a_sector)
            rhc_pkg::SEC_RED:   n_a_num = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
            rhc_pkg::SEC_GREEN: n_a_num = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
            default:            n_a_num = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_sector <= n_a_sector;
            r_a_max    <= n_a_max;
            r_a_min    <= n_a_min;
            r_a_num    <= n_a_num;
        end
    end

    // stage b: delta, magnitude, scaled hue numerator, divider operands
    logic                              r_b_valid;
    rhc_pkg::t_div                     r_b_div;
    rhc_pkg::t_div                     n_b_div;
    logic [rhc_pkg::CH_W-1:0]          n_delta;
    logic [rhc_pkg::CH_W-1:0]          n_abs;
    logic [rhc_pkg::HUE_NUM_W-1:0]     n_prod;

    always_comb begin
        n_delta = r_a_max - r_a_min;
        n_abs   = r_a_num[rhc_pkg::CH_W] ? rhc_pkg::CH_W'(-r_a_num)
                                         : r_a_num[rhc_pkg::CH_W-1:0];
        n_prod  = rhc_pkg::HUE_NUM_W'(n_abs) * rhc_pkg::HUE_NUM_W'(rhc_pkg::HUE_SCALE);

        n_b_div.side.sector = r_a_sector;
        n_b_div.side.neg    = r_a_num[rhc_pkg::CH_W];
        n_b_div.side.grey   = (n_delta == '0);
        n_b_div.side.black  = (r_a_max == '0);
        n_b_div.side.value  = r_a_max;

        n_b_div.sat.nq  = {{(rhc_pkg::DIV_W - rhc_pkg::CH_W - rhc_pkg::SAT_FRAC){1'b0}},
                           n_delta, {rhc_pkg::SAT_FRAC{1'b0}}};
        n_b_div.sat.rem = '0;
        n_b_div.sat.den = r_a_max;

        n_b_div.hue.nq  = rhc_pkg::DIV_W'(n_prod);
        n_b_div.hue.rem = '0;
        n_b_div.hue.den = n_delta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_div <= n_b_div;
        end
    end

    assign o_valid = r_b_valid;
    assign o_div   = r_b_div;

endmodule

[sv/rhc_div.sv]
module rhc_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  rhc_pkg::t_div  i_div,
    output logic           o_valid,
    output rhc_pkg::t_div  o_div
);

    // both quotients advance four bits per stage, side info rides along
    logic           r_valid [rhc_pkg::DIV_STAGES];
    rhc_pkg::t_div  r_stage [rhc_pkg::DIV_STAGES];

    for (genvar s = 0; s < rhc_pkg::DIV_STAGES; s++) begin : g_stage
        rhc_pkg::t_div w_in;
        logic          w_vin;
        rhc_pkg::t_div n_stage;

        if (s == 0) begin : g_first
            assign w_in  = i_div;
            assign w_vin = i_valid;
        end else begin : g_next
            assign w_in  = r_stage[s-1];
            assign w_vin = r_valid[s-1];
        end

        always_comb begin
            n_stage      = w_in;
            n_stage.sat  = rhc_pkg::div_steps(w_in.sat);
            n_stage.hue  = rhc_pkg::div_steps(w_in.hue);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stage[s] <= n_stage;
            end
        end
    end

    assign o_valid = r_valid[rhc_pkg::DIV_STAGES-1];
    assign o_div   = r_stage[rhc_pkg::DIV_STAGES-1];

endmodule

[sv/rhc_post.sv]
module rhc_post (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  rhc_pkg::t_div                 i_div,
    output logic                          o_valid,
    output logic [rhc_pkg::HUE_W-1:0]     o_hue,
    output logic [rhc_pkg::SAT_W-1:0]     o_sat,
    output logic [rhc_pkg::CH_W-1:0]      o_value
);

    logic                          r_valid;
    logic [rhc_pkg::HUE_W-1:0]     r_hue;
    logic [rhc_pkg::SAT_W-1:0]     r_sat;
    logic [rhc_pkg::CH_W-1:0]      r_value;

    logic [rhc_pkg::HUE_W-1:0]     n_hue;
    logic [rhc_pkg::SAT_W-1:0]     n_sat;
    logic [rhc_pkg::HUE_W-1:0]     n_base;
    logic [rhc_pkg::HUE_Q_W-1:0]   n_q;
    logic                          n_round;
    logic [rhc_pkg::HUE_W:0]       n_sum;
    logic [rhc_pkg::HUE_W:0]       n_wrap;

    always_comb begin
        unique case (i_div.side.sector)
            rhc_pkg::SEC_RED:   n_base = rhc_pkg::BASE_RED;
            rhc_pkg::SEC_GREEN: n_base = rhc_pkg::BASE_GREEN;
            default:            n_base = rhc_pkg::BASE_BLUE;
        endcase
        n_q     = i_div.hue.nq[rhc_pkg::HUE_Q_W-1:0];
        n_round = (i_div.hue.rem != '0);
        // negative numerator floors away from zero
        if (i_div.side.neg) begin
            n_sum = {1'b0, n_base} - (rhc_pkg::HUE_W+1)'(n_q) - (rhc_pkg::HUE_W+1)'(n_round);
        end else begin
            n_sum = {1'b0, n_base} + (rhc_pkg::HUE_W+1)'(n_q);
        end
        n_wrap = n_sum[rhc_pkg::HUE_W] ? n_sum + rhc_pkg::FULL_TURN : n_sum;
        n_hue  = i_div.side.grey ? '0 : n_wrap[rhc_pkg::HUE_W-1:0];
        n_sat  = i_div.side.black ? '0 : i_div.sat.nq[rhc_pkg::SAT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hue   <= n_hue;
            r_sat   <= n_sat;
            r_value <= i_div.side.value;
        end
    end

    assign o_valid = r_valid;
    assign o_hue   = r_hue;
    assign o_sat   = r_sat;
    assign o_value = r_value;

endmodule

[sv/rgb_to_hsv_converter.sv]
// RGB to HSV converter: takes one 8-bit RGB pixel per clock and returns hue in 1/64-degree
// units, saturation with 32768 meaning 1.0 and brightness as the largest channel. The block
// is a 9-stage pipeline, and a new pixel can be accepted every cycle while o_ready is high.
// Two max/min and operand stages feed six divider stages that resolve both quotients four
// bits at a time over a 24-bit numerator, and a last stage assembles the hue and holds the
// result. When the result is not taken the whole pipeline holds; o_ready is low only while
// a result waits and i_ready is low.
`include "rgb_to_hsv_converter_macros.svh"

module rgb_to_hsv_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rhc_pkg::CH_W-1:0]      i_red,
    input  logic [rhc_pkg::CH_W-1:0]      i_green,
    input  logic [rhc_pkg::CH_W-1:0]      i_blue,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rhc_pkg::HUE_W-1:0]     o_hue,
    output logic [rhc_pkg::SAT_W-1:0]     o_saturation,
    output logic [rhc_pkg::CH_W-1:0]      o_brightness
);

    logic           w_en;
    logic           w_prep_valid;
    rhc_pkg::t_div  w_prep_div;
    logic           w_div_valid;
    rhc_pkg::t_div  w_div_div;

    // every stage moves together unless the held result is blocked
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    rhc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (w_prep_valid),
        .o_div   (w_prep_div)
    );

    rhc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_prep_valid),
        .i_div   (w_prep_div),
        .o_valid (w_div_valid),
        .o_div   (w_div_div)
    );

    rhc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_valid),
        .i_div   (w_div_div),
        .o_valid (o_valid),
        .o_hue   (o_hue),
        .o_sat   (o_saturation),
        .o_value (o_brightness)
    );

    // zero saturation means zero delta, which covers black as well as gray
    `RHC_ASSERT_IMP(a_sat_range, o_valid, o_saturation <= rhc_pkg::SAT_ONE, "saturation above 1.0")
    `RHC_ASSERT_IMP(a_hue_range, o_valid, {1'b0, o_hue} < rhc_pkg::FULL_TURN, "hue not below 360")
    `RHC_ASSERT_IMP(a_grey_hue, o_valid && o_saturation == '0, o_hue == '0, "nonzero gray hue")
    `RHC_ASSERT_NXT(a_stall_keeps, !o_ready, o_valid, "blocked result dropped")

endmodule
